>>> hw/rtl/nd_strided_copy_address_gen_unit_macros.svh
// ----------------------------------------------------------------------------
// nd strided copy address generator - assertion macros
// Shared property forms for the checker, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ND_STRIDED_COPY_ADDRESS_GEN_UNIT_MACROS_SVH
`define ND_STRIDED_COPY_ADDRESS_GEN_UNIT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define NDSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ndsc check failed: next-cycle property");

// consequent must hold in the same cycle as the antecedent
`define NDSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ndsc check failed: same-cycle property");

`endif

>>> hw/rtl/ndsc_pkg.sv
// ----------------------------------------------------------------------------
// ndsc_pkg
// Types and constants shared by the strided copy address generator.
// ----------------------------------------------------------------------------
package ndsc_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int ADDR_BITS = 32;
    localparam int DIM_CNT_W = $clog2(MAX_DIMS + 1);
    // length of the settling sweep that follows a table or dimension-count change
    localparam int SWEEP_LEN = MAX_DIMS + 2;
    localparam int SWEEP_W   = $clog2(SWEEP_LEN + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [1:0]  dim_select;
        logic [15:0] extent;
        logic [15:0] src_first;
        logic [31:0] src_pitch;
        logic [15:0] dst_first;
        logic [31:0] dst_pitch;
    } t_in_item;

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic        final_element;
    } t_out_item;

    typedef struct packed {
        logic we;
        logic rewind;
        logic step;
        logic in_use;
        logic unit_stride;
    } t_cell_ctrl;

    typedef struct packed {
        logic [ADDR_BITS-1:0] src;
        logic [ADDR_BITS-1:0] dst;
    } t_addr_pair;

    // running sums handed along the chain: start offsets and rewind spans
    typedef struct packed {
        t_addr_pair base;
        t_addr_pair span;
    } t_acc;

    function automatic logic [DIM_CNT_W-1:0] dims_in_use(input logic [2:0] v);
        logic [DIM_CNT_W-1:0] n;
        if (v == 3'd0) begin
            n = DIM_CNT_W'(1);
        end else if (int'(v) > MAX_DIMS) begin
            n = DIM_CNT_W'(MAX_DIMS);
        end else begin
            n = DIM_CNT_W'(v);
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/nd_strided_copy_address_gen_unit.sv
// ----------------------------------------------------------------------------
// nd_strided_copy_address_gen_unit
// Source and destination offset generator for an n-dimensional strided copy.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall, payload i_in): a load transfer writes
// one dimension's extent, starts and pitches and rewinds the walk; a step
// transfer yields the next source/destination offset pair in odometer order.
// i_cfg_we / i_cfg_wdata set the number of dimensions and also rewind.
// Output channel (o_out_valid / i_out_stall, payload o_out): one transfer per
// step, final_element marking the last element before the walk restarts.
// A step's result is registered and shown the cycle after its transfer. Steps
// go at one per cycle, limited by the single cursor add, unless a sweep runs
// or a stalled result waits. After reset, a load or a dimension-count write,
// o_in_stall stays high while the running sums travel down the row of
// dimension cells and settle the per-dimension increments and start offsets.
// Reset is synchronous and starts that same sweep with default tables.
// When the receiver stalls, the result register holds its transfer and the
// input channel, loads included, stays stalled until that result is taken.
// ----------------------------------------------------------------------------
module nd_strided_copy_address_gen_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ndsc_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ndsc_pkg::t_out_item  o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_wdata
);

    localparam int M = ndsc_pkg::MAX_DIMS;

    logic [2:0]                         r_num_dims;
    logic [ndsc_pkg::SWEEP_W-1:0]       r_sweep;
    logic [ndsc_pkg::ADDR_BITS-1:0]     r_src_cur;
    logic [ndsc_pkg::ADDR_BITS-1:0]     r_dst_cur;
    logic                               r_out_valid;
    ndsc_pkg::t_out_item                r_out;

    logic [ndsc_pkg::DIM_CNT_W-1:0]     w_dims;
    logic                               w_busy;
    logic                               w_accept;
    logic                               w_step;
    logic                               w_load;
    logic                               w_rewind;
    logic                               w_final;
    ndsc_pkg::t_cell_ctrl               w_ctrl  [M];
    logic                               w_carry [M+1];
    ndsc_pkg::t_acc                     w_acc   [M+1];
    ndsc_pkg::t_addr_pair               w_sel   [M+1];

    assign w_dims     = ndsc_pkg::dims_in_use(r_num_dims);
    assign w_busy     = (r_sweep != '0);
    assign o_in_stall = w_busy || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_step     = w_accept && (i_in.kind == ndsc_pkg::KIND_STEP);
    assign w_load     = w_accept && (i_in.kind == ndsc_pkg::KIND_LOAD);
    assign w_rewind   = w_load || i_cfg_we;

    assign w_carry[0] = 1'b1;
    assign w_acc[0]   = '0;
    assign w_sel[0]   = '0;
    assign w_final    = w_carry[M];

    always_comb begin
        for (int d = 0; d < M; d++) begin
            w_ctrl[d].we          = w_load && (int'(i_in.dim_select) == d);
            w_ctrl[d].rewind      = w_rewind;
            w_ctrl[d].step        = w_step;
            w_ctrl[d].in_use      = (ndsc_pkg::DIM_CNT_W'(d) < w_dims);
            w_ctrl[d].unit_stride = (d == 0);
        end
    end

    for (genvar d = 0; d < M; d++) begin : g_cell
        ndsc_dim_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[d]),
            .i_entry (i_in),
            .i_carry (w_carry[d]),
            .i_acc   (w_acc[d]),
            .i_sel   (w_sel[d]),
            .o_carry (w_carry[d+1]),
            .o_acc   (w_acc[d+1]),
            .o_sel   (w_sel[d+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 3'd1;
            r_sweep    <= ndsc_pkg::SWEEP_W'(ndsc_pkg::SWEEP_LEN);
        end else begin
            if (i_cfg_we) begin
                r_num_dims <= i_cfg_wdata;
            end
            if (w_rewind) begin
                r_sweep <= ndsc_pkg::SWEEP_W'(ndsc_pkg::SWEEP_LEN);
            end else if (w_busy) begin
                r_sweep <= ndsc_pkg::SWEEP_W'(r_sweep - 1'b1);
            end
        end
    end

    // cursor restarts at the sum of start offsets once the sweep has settled
    always_ff @(posedge i_clk) begin
        if (w_busy && (r_sweep == ndsc_pkg::SWEEP_W'(1))) begin
            r_src_cur <= w_acc[M].base.src;
            r_dst_cur <= w_acc[M].base.dst;
        end else if (w_step) begin
            if (w_final) begin
                r_src_cur <= w_acc[M].base.src;
                r_dst_cur <= w_acc[M].base.dst;
            end else begin
                r_src_cur <= ndsc_pkg::ADDR_BITS'(r_src_cur + w_sel[M].src);
                r_dst_cur <= ndsc_pkg::ADDR_BITS'(r_dst_cur + w_sel[M].dst);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.src_address   <= 32'(r_src_cur);
            r_out.dst_address   <= 32'(r_dst_cur);
            r_out.final_element <= w_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hw/rtl/ndsc_dim_cell.sv
// ----------------------------------------------------------------------------
// ndsc_dim_cell
// One dimension of the walk: table entry, position counter, per-dimension
// products and one stage of the running sums passed to the next cell.
// ----------------------------------------------------------------------------
module ndsc_dim_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ndsc_pkg::t_cell_ctrl  i_ctrl,
    input  ndsc_pkg::t_in_item    i_entry,
    input  logic                  i_carry,
    input  ndsc_pkg::t_acc        i_acc,
    input  ndsc_pkg::t_addr_pair  i_sel,
    output logic                  o_carry,
    output ndsc_pkg::t_acc        o_acc,
    output ndsc_pkg::t_addr_pair  o_sel
);

    logic [15:0]                      r_ext;
    logic [15:0]                      r_src_first;
    logic [31:0]                      r_src_pitch;
    logic [15:0]                      r_dst_first;
    logic [31:0]                      r_dst_pitch;
    logic [15:0]                      r_pos;
    logic [15:0]                      n_pos;
    ndsc_pkg::t_acc                   r_prod;
    ndsc_pkg::t_acc                   r_acc;
    ndsc_pkg::t_addr_pair             r_inc;

    logic [15:0]                      w_ext_m1;
    logic [ndsc_pkg::ADDR_BITS-1:0]   w_src_stride;
    logic [ndsc_pkg::ADDR_BITS-1:0]   w_dst_stride;
    logic                             w_at_end;
    logic                             w_advance;

    // an extent of zero walks like an extent of one
    assign w_ext_m1     = (r_ext == 16'd0) ? 16'd0 : 16'(r_ext - 16'd1);
    assign w_src_stride = i_ctrl.unit_stride ? ndsc_pkg::ADDR_BITS'(1)
                                             : ndsc_pkg::ADDR_BITS'(r_src_pitch);
    assign w_dst_stride = i_ctrl.unit_stride ? ndsc_pkg::ADDR_BITS'(1)
                                             : ndsc_pkg::ADDR_BITS'(r_dst_pitch);

    // unused dimensions pass the carry straight on
    assign w_at_end  = !i_ctrl.in_use || (r_pos == w_ext_m1);
    assign w_advance = i_carry && !w_at_end;
    assign o_carry   = i_carry && w_at_end;
    assign o_sel     = w_advance ? r_inc : i_sel;
    assign o_acc     = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext       <= 16'd1;
            r_src_first <= 16'd0;
            r_src_pitch <= 32'd0;
            r_dst_first <= 16'd0;
            r_dst_pitch <= 32'd0;
        end else if (i_ctrl.we) begin
            r_ext       <= i_entry.extent;
            r_src_first <= i_entry.src_first;
            r_src_pitch <= i_entry.src_pitch;
            r_dst_first <= i_entry.dst_first;
            r_dst_pitch <= i_entry.dst_pitch;
        end
    end

    always_comb begin
        n_pos = r_pos;
        priority if (i_ctrl.rewind) begin
            n_pos = 16'd0;
        end else if (i_ctrl.step && w_advance) begin
            n_pos = 16'(r_pos + 16'd1);
        end else if (i_ctrl.step && i_carry) begin
            n_pos = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 16'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // products and sums recompute every cycle; the top waits out the sweep
    always_ff @(posedge i_clk) begin
        r_prod.base.src <= ndsc_pkg::ADDR_BITS'(
            ndsc_pkg::ADDR_BITS'(r_src_first) * w_src_stride);
        r_prod.base.dst <= ndsc_pkg::ADDR_BITS'(
            ndsc_pkg::ADDR_BITS'(r_dst_first) * w_dst_stride);
        r_prod.span.src <= ndsc_pkg::ADDR_BITS'(
            ndsc_pkg::ADDR_BITS'(w_ext_m1) * w_src_stride);
        r_prod.span.dst <= ndsc_pkg::ADDR_BITS'(
            ndsc_pkg::ADDR_BITS'(w_ext_m1) * w_dst_stride);

        r_acc.base.src <= ndsc_pkg::ADDR_BITS'(i_acc.base.src +
            (i_ctrl.in_use ? r_prod.base.src : '0));
        r_acc.base.dst <= ndsc_pkg::ADDR_BITS'(i_acc.base.dst +
            (i_ctrl.in_use ? r_prod.base.dst : '0));
        r_acc.span.src <= ndsc_pkg::ADDR_BITS'(i_acc.span.src +
            (i_ctrl.in_use ? r_prod.span.src : '0));
        r_acc.span.dst <= ndsc_pkg::ADDR_BITS'(i_acc.span.dst +
            (i_ctrl.in_use ? r_prod.span.dst : '0));

        // stepping here rewinds every lower dimension
        r_inc.src <= ndsc_pkg::ADDR_BITS'(w_src_stride - i_acc.span.src);
        r_inc.dst <= ndsc_pkg::ADDR_BITS'(w_dst_stride - i_acc.span.dst);
    end

endmodule

>>> hw/rtl/ndsc_checker.sv
// ----------------------------------------------------------------------------
// ndsc_checker
// Port-level checks for the strided copy address generator, bound to the top.
// ----------------------------------------------------------------------------
`include "nd_strided_copy_address_gen_unit_macros.svh"

module ndsc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_stall,
    input ndsc_pkg::t_in_item   i_in,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input ndsc_pkg::t_out_item  i_out,
    input logic                 i_cfg_we
);

    logic w_in_xfer;
    logic w_step_xfer;

    assign w_in_xfer   = i_in_valid && !i_in_stall;
    assign w_step_xfer = w_in_xfer && (i_in.kind == ndsc_pkg::KIND_STEP);

    // a stalled result stays offered and unchanged
    `NDSC_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid)
    `NDSC_ASSERT_NEXT(a_out_stable, i_out_valid && i_out_stall, $stable(i_out))

    // any rewind must block the input while the sums resettle
    `NDSC_ASSERT_NEXT(a_rewind_stall, (w_in_xfer && !w_step_xfer) || i_cfg_we, i_in_stall)

    // a new result only follows a step transfer
    `NDSC_ASSERT_SAME(a_result_source, $rose(i_out_valid), $past(w_step_xfer))

endmodule

bind nd_strided_copy_address_gen_unit ndsc_checker u_ndsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in        (i_in),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out),
    .i_cfg_we    (i_cfg_we)
);
